@@ src/nsr_pkg.sv @@
// Shared types and constants for the nearest-sample resampler.
// No dependencies; imported by every module of the block.
`default_nettype none
package nsr_pkg;

  localparam int COUNT_BITS = 20;   // width of the output counter and output_count
  localparam int POS_BITS   = 32;   // 24.8 position, wraps
  localparam int IDX_BITS   = 24;   // source index, wraps
  localparam int RUN_BITS   = 7;    // outputs per item, 0..64
  localparam int CFG_W      = 20;   // widest register
  localparam int CFG_IDX_W  = 2;

  localparam logic [RUN_BITS-1:0] RUN_MAX = RUN_BITS'(64);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STEP_FIXED      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_IS_16BIT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_IS_16BIT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_COUNT    = 2'd3;

  localparam logic [15:0] STEP_RESET = 16'd256;

  typedef struct packed {
    logic [15:0] source_sample;
    logic        first_of_sound;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] out_sample;
    logic               last_of_run;
    logic               sound_done;
  } out_item_t;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EMIT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;     // take the input item, clear state on first_of_sound
    logic emit;     // produce one output item
    logic finish;   // run over without an output this cycle: bump index
  } nsr_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic more;       // another output is due for the current sample
    logic out_free;   // output register can take an item
    logic emit_last;  // the output being emitted ends the run
  } nsr_stat_t;

endpackage
`default_nettype wire

@@ src/nearest_sample_resampler_top.sv @@
// Top level of the nearest-sample resampler: controller plus datapath.
// Depends on nsr_pkg, nsr_ctrl and nsr_dp.
`default_nettype none
// Nearest-sample rate converter. Source samples (unsigned 8-bit, centered
// and scaled to 16 bits, or signed 16-bit) come in on the in_ channel; for
// each one the block emits every output whose 24.8 position has an integer
// part at or below the sample's index, at most 64 per item, until
// output_count outputs have been produced for the sound. first_of_sound
// restarts position, index and count. The item is taken in the idle state,
// then outputs are emitted while the output register is free. The block
// works on one item at a time, so the rate is set by the single output
// register fed by the emit loop of the controller. The output register lets
// the next item be taken while the last result still waits. Registers are
// written through cfg_we/cfg_index/cfg_data; the user must write them only
// while the block is idle, which the block does not enforce: 0 step_fixed,
// 1 input_is_16bit, 2 output_is_16bit, 3 output_count.
module nearest_sample_resampler_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [nsr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [nsr_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire nsr_pkg::in_item_t             in_item,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output nsr_pkg::out_item_t                 out_item
);
  import nsr_pkg::*;

  nsr_cmd_t  cmd;
  nsr_stat_t st;

  // sequencing: idle -> emit loop -> idle
  nsr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // state, conversion and output register
  nsr_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire

@@ src/nsr_ctrl.sv @@
// Controller state machine of the resampler.
// Depends on nsr_pkg; drives commands into nsr_dp.
`default_nettype none
module nsr_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire nsr_pkg::nsr_stat_t st,
  output nsr_pkg::nsr_cmd_t      cmd
);
  import nsr_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!st.more) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end else if (st.out_free) begin
          cmd.emit = 1'b1;
          if (st.emit_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_load_to_emit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == ST_EMIT)
    else $error("load did not enter emit state");
  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.emit && cmd.finish) && !(cmd.load && (cmd.emit || cmd.finish)))
    else $error("conflicting datapath commands");
  a_end_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && !st.more) |=> state_r == ST_IDLE)
    else $error("run did not end when no output was due");
`endif

endmodule
`default_nettype wire

@@ src/nsr_dp.sv @@
// Datapath of the resampler: config registers, position/index/count state,
// sample conversion and the output register. Depends on nsr_pkg.
`default_nettype none
module nsr_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [nsr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [nsr_pkg::CFG_W-1:0]     cfg_data,
  input  wire nsr_pkg::in_item_t             in_item,
  input  wire nsr_pkg::nsr_cmd_t             cmd,
  output nsr_pkg::nsr_stat_t                 st,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output nsr_pkg::out_item_t                 out_item
);
  import nsr_pkg::*;

  // configuration
  logic [15:0]           step_r;
  logic                  in16_r;
  logic                  out16_r;
  logic [COUNT_BITS-1:0] target_r;

  // sound state
  logic [POS_BITS-1:0]   pos_r, pos_nxt;
  logic [IDX_BITS-1:0]   idx_r, idx_nxt;
  logic [COUNT_BITS-1:0] done_r, done_nxt;
  logic [RUN_BITS-1:0]   n_r, n_nxt;
  logic [15:0]           smp_r;

  logic                  out_valid_r;
  out_item_t             out_item_r;

  logic [POS_BITS-1:0]   pos_sum;
  logic [COUNT_BITS-1:0] done_inc;
  logic [15:0]           wide_smp, conv_smp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r   <= STEP_RESET;
      in16_r   <= 1'b0;
      out16_r  <= 1'b0;
      target_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STEP_FIXED:      step_r   <= cfg_data[15:0];
        REG_INPUT_IS_16BIT:  in16_r   <= cfg_data[0];
        REG_OUTPUT_IS_16BIT: out16_r  <= cfg_data[0];
        REG_OUTPUT_COUNT:    target_r <= cfg_data[COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // byte - 128, scaled by 256: flip the sign bit and append zeros
  assign wide_smp = in16_r ? in_item.source_sample
                           : {in_item.source_sample[7] ^ 1'b1,
                              in_item.source_sample[6:0], 8'h00};
  // arithmetic shift right by 8
  assign conv_smp = out16_r ? wide_smp : {{8{wide_smp[15]}}, wide_smp[15:8]};

  assign pos_sum  = pos_r + POS_BITS'(step_r);
  assign done_inc = done_r + COUNT_BITS'(1);

  always_comb begin
    st.out_free  = !out_valid_r || !out_stall;
    st.more      = (n_r != RUN_MAX) && (done_r < target_r) &&
                   (pos_r[POS_BITS-1:8] <= idx_r);
    st.emit_last = (n_r == RUN_MAX - RUN_BITS'(1)) || (done_inc == target_r) ||
                   (pos_sum[POS_BITS-1:8] > idx_r);
  end

  always_comb begin
    pos_nxt  = pos_r;
    idx_nxt  = idx_r;
    done_nxt = done_r;
    n_nxt    = n_r;
    if (cmd.load) begin
      n_nxt = '0;
      if (in_item.first_of_sound) begin
        pos_nxt  = '0;
        idx_nxt  = '0;
        done_nxt = '0;
      end
    end else if (cmd.emit) begin
      pos_nxt  = pos_sum;
      done_nxt = done_inc;
      n_nxt    = n_r + RUN_BITS'(1);
      if (st.emit_last) begin
        idx_nxt = idx_r + IDX_BITS'(1);
      end
    end else if (cmd.finish) begin
      idx_nxt = idx_r + IDX_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      idx_r       <= '0;
      done_r      <= '0;
      n_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      idx_r  <= idx_nxt;
      done_r <= done_nxt;
      n_r    <= n_nxt;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      smp_r <= conv_smp;
    end
    if (cmd.emit) begin
      out_item_r.out_sample  <= smp_r;
      out_item_r.last_of_run <= st.emit_last;
      out_item_r.sound_done  <= (done_inc == target_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef ASSERT_OFF
  a_run_cap: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= RUN_MAX)
    else $error("more than 64 outputs in one run");
  a_emit_below_target: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (done_r < target_r) && st.out_free)
    else $error("emit past output count or into a full register");
  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!cmd.emit && !cmd.load && !cfg_we) |=> $stable(done_r))
    else $error("output count moved without an emit");
`endif

endmodule
`default_nettype wire

@@ dv/nearest_sample_resampler_top_test.sv @@
// Self-checking testbench for nearest_sample_resampler_top.
// Needs nsr_pkg and the resampler RTL; it stands alone otherwise.
`timescale 1ns / 100ps
module nearest_sample_resampler_top_test;
  import nsr_pkg::*;

  localparam int HALF_PERIOD  = 6;
  localparam int RESET_CYCLES = 8;
  localparam int RANDOM_ITEMS = 200;
  localparam int RUN_CAP      = 64;    // outputs one source item may cause
  localparam int DRAIN_CYCLES = 4;     // margin for an item that yields no output
  localparam int HANG_LIMIT   = 2000;  // cycles with no item moving on either side
  localparam int MAX_REPORTS  = 10;
  localparam int NUM_DIRECTED = 23;

  // DUT ports; every input has a known value from time zero.
  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_STEP_FIXED;
  logic [CFG_W-1:0]     cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_item_t             in_item   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_item;

  nearest_sample_resampler_top uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  always #HALF_PERIOD clk = ~clk;

  // ---------------------------------------------------------------------------
  // Resampler prediction: our own copy of the registers and the running state.
  // ---------------------------------------------------------------------------
  logic [15:0]           step_reg   = STEP_RESET;
  logic                  in16_reg   = 1'b0;
  logic                  out16_reg  = 1'b0;
  logic [COUNT_BITS-1:0] target_reg = '0;

  logic [POS_BITS-1:0]   out_pos    = '0;   // 24.8 position of the next output
  logic [IDX_BITS-1:0]   src_idx    = '0;   // index of the sample being taken
  logic [COUNT_BITS-1:0] made_cnt   = '0;   // outputs produced for this sound

  out_item_t due_outputs[$];               // outputs still owed by the block

  // Advances the state by one source item. When keep is set the outputs it
  // causes are queued; directed rows with typed answers pass keep = 0.
  function automatic int resample_item(in_item_t it, bit keep);
    logic signed [15:0] wide;
    logic signed [15:0] value;
    out_item_t          held;
    out_item_t          nxt;
    bit                 have;
    int                 n;
    have = 1'b0;
    n    = 0;
    if (it.first_of_sound) begin
      out_pos  = '0;
      src_idx  = '0;
      made_cnt = '0;
    end
    // 8-bit source: byte - 128 is the byte with its top bit flipped, then x256.
    wide  = in16_reg ? it.source_sample : {it.source_sample[7:0] ^ 8'h80, 8'h00};
    value = out16_reg ? wide : {{8{wide[15]}}, wide[15:8]};
    // Every output whose integer position has reached the current index,
    // capped per item; anything past the cap stays due for the next item.
    while (n < RUN_CAP && made_cnt < target_reg && out_pos[POS_BITS-1:8] <= src_idx) begin
      out_pos  = out_pos + POS_BITS'(step_reg);
      made_cnt = made_cnt + 1'b1;
      nxt.out_sample  = value;
      nxt.last_of_run = 1'b0;
      nxt.sound_done  = (made_cnt == target_reg);
      if (have && keep) due_outputs.push_back(held);
      held = nxt;
      have = 1'b1;
      n++;
    end
    if (have && keep) begin
      held.last_of_run = 1'b1;
      due_outputs.push_back(held);
    end
    src_idx = src_idx + 1'b1;
    return n;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  int mismatches     = 0;
  int outputs_seen   = 0;
  int run_len        = 0;
  int longest_run    = 0;
  int sounds_done    = 0;

  task automatic log_mismatch(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("tb: mismatch: %s", msg);
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      outputs_seen++;
      run_len++;
      if (out_item.last_of_run) begin
        if (run_len > longest_run) longest_run = run_len;
        run_len = 0;
      end
      if (out_item.sound_done) sounds_done++;
      if (due_outputs.size() == 0) begin
        log_mismatch($sformatf("output with nothing expected: sample %h last %b done %b",
                               out_item.out_sample, out_item.last_of_run,
                               out_item.sound_done));
      end else begin
        want = due_outputs.pop_front();
        if (out_item.out_sample !== want.out_sample ||
            out_item.last_of_run !== want.last_of_run ||
            out_item.sound_done !== want.sound_done) begin
          log_mismatch($sformatf("output %0d: sample %h/%h last %b/%b done %b/%b (exp/got)",
                                 outputs_seen, want.out_sample, out_item.out_sample,
                                 want.last_of_run, out_item.last_of_run,
                                 want.sound_done, out_item.sound_done));
        end
      end
    end
  end

  // Watchdog: a hung block shows up as a long stretch where no item moves.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= HANG_LIMIT) begin
        $display("tb: no progress for %0d cycles", HANG_LIMIT);
        $display("tb: failure");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stalls follow a 16-bit pattern, redrawn each window as clear,
  // light, even or heavy, so stalls land on every phase of a run.
  // ---------------------------------------------------------------------------
  logic [15:0] stall_bits  = '0;
  logic [3:0]  stall_phase = '0;

  always @(negedge clk) begin
    if (stall_phase == 4'd0) begin
      case ($urandom_range(0, 3))
        0:       stall_bits = '0;
        1:       stall_bits = 16'($urandom);
        2:       stall_bits = 16'($urandom & $urandom);
        default: stall_bits = 16'($urandom | $urandom);
      endcase
    end
    out_stall   = stall_bits[stall_phase];
    stall_phase = stall_phase + 1'b1;
  end

  // ---------------------------------------------------------------------------
  // Sender: items go out in bursts; between bursts valid drops for a while unless gapless is set.
  // Inputs change only at the falling edge.
  // ---------------------------------------------------------------------------
  int samples_sent = 0;
  int burst_left   = 0;
  bit gapless      = 1'b0;

  task automatic pace();
    if (burst_left == 0) begin
      if (!gapless) begin
        repeat ($urandom_range(1, 6)) begin
          @(negedge clk);
          in_valid = 1'b0;
        end
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
  endtask

  // Offers one item, holds it until taken, then runs it through the predictor.
  task automatic send_sample(in_item_t it, bit keep);
    @(negedge clk);
    in_valid = 1'b1;
    in_item  = it;
    do @(posedge clk); while (in_stall);
    void'(resample_item(it, keep));
    samples_sent++;
  endtask

  // Drops valid and waits until every owed output is out, plus the cycles a
  // run with no output may still need.
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (due_outputs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Register writes, only while drained.
  // ---------------------------------------------------------------------------
  int settings_used = 0;

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    case (idx)
      REG_STEP_FIXED:      step_reg   = data[15:0];
      REG_INPUT_IS_16BIT:  in16_reg   = data[0];
      REG_OUTPUT_IS_16BIT: out16_reg  = data[0];
      REG_OUTPUT_COUNT:    target_reg = data[COUNT_BITS-1:0];
      default: ;
    endcase
  endtask

  // junk fills the unused upper data bits; the block must ignore them.
  task automatic program_regs(logic [15:0] step, logic in16, logic out16,
                              logic [COUNT_BITS-1:0] count, logic [CFG_W-1:0] junk);
    write_reg(REG_STEP_FIXED,      {junk[CFG_W-1:16], step});
    write_reg(REG_INPUT_IS_16BIT,  {junk[CFG_W-1:1], in16});
    write_reg(REG_OUTPUT_IS_16BIT, {junk[CFG_W-1:1], out16});
    write_reg(REG_OUTPUT_COUNT,    count);
    @(negedge clk);
    cfg_we = 1'b0;
    settings_used++;
  endtask

  // ---------------------------------------------------------------------------
  // Directed rows. Rows marked typed carry their answer: n copies of value,
  // last_of_run on the final one, sound_done there too when done is set.
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic                  reconfig;
    logic [15:0]           step;
    logic                  in16;
    logic                  out16;
    logic [COUNT_BITS-1:0] count;
    logic [15:0]           sample;
    logic                  first;
    logic                  typed;
    logic [6:0]            n;
    logic [15:0]           value;
    logic                  done;
  } stim_row_t;

  stim_row_t directed_rows [NUM_DIRECTED] = '{
    // reset values: output count is zero, nothing comes out
    '{1'b0, 16'd0,     1'b0, 1'b0, 20'd0,     16'h00FF, 1'b1, 1'b1, 7'd0,  16'h0000, 1'b0},
    // unit step, 8-bit in and out: byte - 128, one output per item
    '{1'b1, 16'd256,   1'b0, 1'b0, 20'd5,     16'h0000, 1'b1, 1'b1, 7'd1,  16'hFF80, 1'b0},
    '{1'b0, 16'd0,     1'b0, 1'b0, 20'd0,     16'hABFF, 1'b0, 1'b1, 7'd1,  16'h007F, 1'b0},
    '{1'b0, 16'd0,     1'b0, 1'b0, 20'd0,     16'h0080, 1'b0, 1'b1, 7'd1,  16'h0000, 1'b0},
    '{1'b0, 16'd0,     1'b0, 1'b0, 20'd0,     16'h007F, 1'b0, 1'b1, 7'd1,  16'hFFFF, 1'b0},
    '{1'b0, 16'd0,     1'b0, 1'b0, 20'd0,     16'hFF01, 1'b0, 1'b1, 7'd1,  16'hFF81, 1'b1},
    // count reached: silent until the next sound starts
    '{1'b0, 16'd0,     1'b0, 1'b0, 20'd0,     16'h0040, 1'b0, 1'b1, 7'd0,  16'h0000, 1'b0},
    '{1'b0, 16'd0,     1'b0, 1'b0, 20'd0,     16'h0040, 1'b1, 1'b0, 7'd0,  16'h0000, 1'b0},
    // smallest legal step, 16-bit through, largest count: full runs of 64
    '{1'b1, 16'd4,     1'b1, 1'b1, 20'hFFFFF, 16'h8000, 1'b1, 1'b1, 7'd64, 16'h8000, 1'b0},
    '{1'b0, 16'd0,     1'b0, 1'b0, 20'd0,     16'h7FFF, 1'b0, 1'b1, 7'd64, 16'h7FFF, 1'b0},
    '{1'b0, 16'd0,     1'b0, 1'b0, 20'd0,     16'hFFFF, 1'b0, 1'b1, 7'd64, 16'hFFFF, 1'b0},
    // step below 4: the cap leaves outputs due and the position lags
    '{1'b1, 16'd2,     1'b1, 1'b0, 20'd200,   16'h8000, 1'b1, 1'b1, 7'd64, 16'hFF80, 1'b0},
    '{1'b0, 16'd0,     1'b0, 1'b0, 20'd0,     16'h7FFF, 1'b0, 1'b0, 7'd0,  16'h0000, 1'b0},
    '{1'b0, 16'd0,     1'b0, 1'b0, 20'd0,     16'h1234, 1'b0, 1'b0, 7'd0,  16'h0000, 1'b0},
    '{1'b0, 16'd0,     1'b0, 1'b0, 20'd0,     16'h0100, 1'b0, 1'b0, 7'd0,  16'h0000, 1'b0},
    // zero step: 64 per item until the count is hit
    '{1'b1, 16'd0,     1'b0, 1'b1, 20'd100,   16'h0012, 1'b1, 1'b1, 7'd64, 16'h9200, 1'b0},
    '{1'b0, 16'd0,     1'b0, 1'b0, 20'd0,     16'h3434, 1'b0, 1'b1, 7'd36, 16'hB400, 1'b1},
    '{1'b0, 16'd0,     1'b0, 1'b0, 20'd0,     16'h5555, 1'b0, 1'b1, 7'd0,  16'h0000, 1'b0},
    // largest step: one output, then a long silence; restart mid-sound
    '{1'b1, 16'hFFFF,  1'b1, 1'b1, 20'd3,     16'h1234, 1'b1, 1'b1, 7'd1,  16'h1234, 1'b0},
    '{1'b0, 16'd0,     1'b0, 1'b0, 20'd0,     16'h4321, 1'b0, 1'b0, 7'd0,  16'h0000, 1'b0},
    '{1'b0, 16'd0,     1'b0, 1'b0, 20'd0,     16'h0001, 1'b1, 1'b1, 7'd1,  16'h0001, 1'b0},
    // 8-bit in, 16-bit out, single-output sound
    '{1'b1, 16'd256,   1'b0, 1'b1, 20'd1,     16'h00FF, 1'b1, 1'b1, 7'd1,  16'h7F00, 1'b1},
    // zero output count with a small step
    '{1'b1, 16'd3,     1'b1, 1'b1, 20'd0,     16'h8001, 1'b1, 1'b1, 7'd0,  16'h0000, 1'b0}
  };

  logic [15:0] corner_samples [6] = '{16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF,
                                      16'h0080, 16'h007F};

  function automatic logic [15:0] pick_sample();
    if ($urandom_range(0, 7) == 0) return corner_samples[$urandom_range(0, 5)];
    return 16'($urandom);
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    stim_row_t             row;
    in_item_t              it;
    out_item_t             typed_out;
    logic [15:0]           step;
    logic [COUNT_BITS-1:0] count;
    int                    random_sent;
    int                    phase_len;
    bit                    noisy;

    random_sent = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part: a table walk; registers change only once drained.
    for (int r = 0; r < NUM_DIRECTED; r++) begin
      row = directed_rows[r];
      if (row.reconfig) begin
        drain();
        program_regs(row.step, row.in16, row.out16, row.count, '0);
      end
      it.source_sample  = row.sample;
      it.first_of_sound = row.first;
      pace();
      send_sample(it, !row.typed);
      for (int k = 0; k < int'(row.n); k++) begin
        typed_out.out_sample  = row.value;
        typed_out.last_of_run = (k == int'(row.n) - 1);
        typed_out.sound_done  = (k == int'(row.n) - 1) && row.done;
        due_outputs.push_back(typed_out);
      end
    end

    // Random part: each phase drains, picks a setting, then sends a run of items.
    // Mostly well-formed (first item starts the sound, rare restarts);
    // about one phase in ten scrambles first_of_sound.
    while (random_sent < RANDOM_ITEMS) begin
      drain();
      case ($urandom_range(0, 9))
        0:       step = 16'($urandom_range(0, 3));
        1:       step = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'($urandom_range(1024, 65535));
        default: step = 16'($urandom_range(4, 600));
      endcase
      case ($urandom_range(0, 9))
        0:       count = '0;
        1:       count = '1;
        default: count = COUNT_BITS'($urandom_range(1, 150));
      endcase
      program_regs(step, 1'($urandom), 1'($urandom), count, CFG_W'($urandom));

      phase_len = $urandom_range(8, 30);
      gapless   = ($urandom_range(0, 3) == 0);
      noisy     = ($urandom_range(0, 9) == 0);
      for (int k = 0; k < phase_len; k++) begin
        it.source_sample  = pick_sample();
        it.first_of_sound = noisy ? 1'($urandom)
                                  : (k == 0 || $urandom_range(0, 24) == 0);
        // now and then hold off until the block has caught up completely
        if ($urandom_range(0, 19) == 0) drain();
        pace();
        send_sample(it, 1'b1);
        random_sent++;
      end
    end

    // Wind down: everything owed must arrive, then watch for stragglers.
    drain();
    repeat (10) @(posedge clk);

    $display("tb: %0d source items (%0d directed) under %0d register settings, %0d outputs",
             samples_sent, NUM_DIRECTED, settings_used, outputs_seen);
    $display("tb: longest run %0d outputs, %0d sounds completed, %0d mismatches",
             longest_run, sounds_done, mismatches);
    if (mismatches == 0 && due_outputs.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/nsr_pkg.sv
src/nsr_ctrl.sv
src/nsr_dp.sv
src/nearest_sample_resampler_top.sv
dv/nearest_sample_resampler_top_test.sv
